>>> src/lcbc_pkg.sv
// Shared types, constants and helper functions for the Luhn card check block.
// Used by lcbc_ctrl, lcbc_dp and luhn_card_brand_check; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package lcbc_pkg;

	localparam int CARD_W     = 63;
	localparam int BIN_W      = 64;          // card number padded to a multiple of 4 bits
	localparam int DIGITS     = 20;          // BCD digits, enough for 19 decimal digits
	localparam int BCD_W      = 4 * DIGITS;
	localparam int BITS_STEP  = 4;           // binary bits converted per cycle
	localparam int CONV_STEPS = BIN_W / BITS_STEP;
	localparam int SUM_STEPS  = DIGITS / 2;  // two digits summed per cycle
	localparam int CNT_W      = $clog2(CONV_STEPS + SUM_STEPS);
	localparam int NDIG_W     = $clog2(DIGITS + 1);

	typedef enum logic [1:0] {
		BRAND_NONE    = 2'd0,
		BRAND_LEAD_3X = 2'd1,
		BRAND_LEAD_5X = 2'd2,
		BRAND_LEAD_4  = 2'd3
	} brand_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CONV,
		S_SUM,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic conv;
		logic sum;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic conv_last;
		logic sum_last;
	} status_t;

	// One double-dabble bit: add 3 to every digit of 5 or more, then shift the bit in.
	function automatic logic [BCD_W-1:0] dd_bit(input logic [BCD_W-1:0] bcd, input logic b);
		logic [BCD_W-1:0] adj;
		adj = bcd;
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd[4*i +: 4] >= 4'd5)
				adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
		end
		return {adj[BCD_W-2:0], b};
	endfunction

	// Luhn contribution of a digit in a doubled position.
	function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
		logic [4:0] t;
		t = {d, 1'b0};
		if (t > 5'd9)
			return 4'(t - 5'd9);
		return 4'(t);
	endfunction

	// Brand of a number given as BCD digits, least significant digit first.
	function automatic brand_t classify(input logic [BCD_W-1:0] bcd);
		logic [NDIG_W-1:0] ndig;
		logic              lead4;
		ndig = '0;
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd[4*i +: 4] != 4'd0)
				ndig = NDIG_W'(i + 1);
		end
		lead4 = (ndig == NDIG_W'(13) && bcd[4*12 +: 4] == 4'd4) ||
			(ndig == NDIG_W'(14) && bcd[4*13 +: 4] == 4'd4) ||
			(ndig == NDIG_W'(15) && bcd[4*14 +: 4] == 4'd4) ||
			(ndig == NDIG_W'(16) && bcd[4*15 +: 4] == 4'd4);
		if (ndig == NDIG_W'(16) && bcd[4*15 +: 4] == 4'd5 &&
		    bcd[4*14 +: 4] >= 4'd1 && bcd[4*14 +: 4] <= 4'd5)
			return BRAND_LEAD_5X;
		if (ndig == NDIG_W'(15) && bcd[4*14 +: 4] == 4'd3 &&
		    (bcd[4*13 +: 4] == 4'd4 || bcd[4*13 +: 4] == 4'd7))
			return BRAND_LEAD_3X;
		if (lead4)
			return BRAND_LEAD_4;
		return BRAND_NONE;
	endfunction

endpackage
`default_nettype wire

>>> src/luhn_card_brand_check.sv
// Luhn mod-10 check with card brand classification, top level.
// Instantiates lcbc_ctrl and lcbc_dp; uses lcbc_pkg.
//
// Input channel: in_valid / in_ready with card_number (63-bit unsigned).
// Output channel: out_valid / out_ready with brand (2 bits) and luhn_ok.
// One result word per input word, in order.
//
// The number is converted to 20 BCD digits, four binary bits per cycle,
// then the digits are summed two per cycle into a mod-10 accumulator;
// classification is taken from the BCD digits. The block works on one word
// at a time: a new word is taken only once the last result has been emitted.
//
// The result sits in an output register: a new input word is accepted while
// an earlier result still waits. If the receiver stalls, the finished word
// waits in the last step until the output register frees up, and no new
// input is taken meanwhile.
// Reset returns the controller to idle, clears the datapath step counter and
// drops out_valid; the other datapath registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module luhn_card_brand_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [62:0] card_number,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       brand,
	output logic             luhn_ok
);
	import lcbc_pkg::*;

	cmd_t    cmd;
	status_t status;

	lcbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	lcbc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.card_number (card_number),
		.status      (status),
		.brand       (brand),
		.luhn_ok     (luhn_ok)
	);

endmodule
`default_nettype wire

>>> src/lcbc_dp.sv
// Datapath: binary-to-BCD converter, Luhn mod-10 accumulator, brand classifier
// and the result register. Driven by lcbc_ctrl commands; uses lcbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lcbc_dp (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire lcbc_pkg::cmd_t            cmd,
	input  wire logic [lcbc_pkg::CARD_W-1:0] card_number,
	output lcbc_pkg::status_t              status,
	output logic [1:0]                     brand,
	output logic                           luhn_ok
);
	import lcbc_pkg::*;

	logic [BIN_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] bcd_conv;
	logic [CNT_W-1:0] cnt_q;
	logic [3:0]       acc_q;
	logic [4:0]       acc_sum;
	logic [3:0]       acc_next;
	brand_t           cand_q;
	logic [1:0]       brand_q;
	logic             ok_q;

	always_comb begin
		bcd_conv = bcd_q;
		for (int k = 0; k < BITS_STEP; k++)
			bcd_conv = dd_bit(bcd_conv, bin_q[BIN_W-1-k]);
	end

	// Low digit plain, next digit doubled; keep the total mod 10.
	always_comb begin
		acc_sum = 5'(acc_q) + 5'(bcd_q[3:0]) + 5'(luhn_dbl(bcd_q[7:4]));
		priority if (acc_sum >= 5'd20)
			acc_next = 4'(acc_sum - 5'd20);
		else if (acc_sum >= 5'd10)
			acc_next = 4'(acc_sum - 5'd10);
		else
			acc_next = 4'(acc_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.conv || cmd.sum) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= {{(BIN_W-CARD_W){1'b0}}, card_number};
			bcd_q <= '0;
			acc_q <= '0;
		end else if (cmd.conv) begin
			bin_q <= {bin_q[BIN_W-BITS_STEP-1:0], {BITS_STEP{1'b0}}};
			bcd_q <= bcd_conv;
		end else if (cmd.sum) begin
			// Classify on the first sum cycle, before any digit is shifted out.
			if (cnt_q == CNT_W'(CONV_STEPS))
				cand_q <= classify(bcd_q);
			bcd_q <= {8'd0, bcd_q[BCD_W-1:8]};
			acc_q <= acc_next;
		end
		if (cmd.emit) begin
			ok_q    <= (acc_q == 4'd0);
			brand_q <= (acc_q == 4'd0) ? 2'(cand_q) : 2'(BRAND_NONE);
		end
	end

	assign status = '{
		conv_last: (cnt_q == CNT_W'(CONV_STEPS - 1)),
		sum_last:  (cnt_q == CNT_W'(CONV_STEPS + SUM_STEPS - 1))
	};
	assign brand   = brand_q;
	assign luhn_ok = ok_q;

endmodule
`default_nettype wire

>>> src/lcbc_ctrl.sv
// Controller: sequences load, conversion, summing and result hand-off, and owns
// both handshakes. Uses lcbc_pkg; drives lcbc_dp by command word.
`timescale 1ns / 1ps
`default_nettype none
module lcbc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire lcbc_pkg::status_t status,
	output lcbc_pkg::cmd_t         cmd
);
	import lcbc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CONV;
				end
			end
			S_CONV: begin
				cmd.conv = 1'b1;
				if (status.conv_last)
					state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				if (status.sum_last)
					state_d = S_DONE;
			end
			S_DONE: begin
				// hold until the result register is free or being drained
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result overwritten while still pending");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.conv && cmd.sum) && !(cmd.load && cmd.emit))
		else $error("conflicting datapath commands");

	a_accept_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_CONV))
		else $error("accepted word did not start conversion");

	a_sum_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM && status.sum_last) |=> (state_q == S_DONE))
		else $error("summing did not finish on the last step");

endmodule
`default_nettype wire
